// ===== rtl/in_place_matrix_transpose_core_assert.svh =====
// Assertion macros shared by the in-place transpose RTL; clk and rst are taken from the module.
`ifndef IN_PLACE_MATRIX_TRANSPOSE_CORE_ASSERT_SVH
`define IN_PLACE_MATRIX_TRANSPOSE_CORE_ASSERT_SVH

// Same-cycle implication.
`define IMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("in_place_matrix_transpose_core: same-cycle check failed");

// Next-cycle implication.
`define IMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("in_place_matrix_transpose_core: next-cycle check failed");

`endif

// ===== rtl/imt_pkg.sv =====
// Shared constants, codes and control structs of the in-place transpose block.
package imt_pkg;

  localparam int IMT_DEPTH      = 1024;
  localparam int IMT_WORD_WIDTH = 64;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 64;
  localparam int KIND_W   = 2;
  localparam int DIM_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ      = 2'd2;

  localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

  typedef struct packed {
    logic rd;
    logic wr;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    logic fin;
    logic refused;
  } seq_stat_t;

endpackage

// ===== rtl/imt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module imt_ram
  import imt_pkg::*;
#(
  parameter int WIDTH = IMT_WORD_WIDTH,
  parameter int DEPTH = IMT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/imt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module imt_div
  import imt_pkg::*;
#(
  parameter int DVD_W = INDEX_W,
  parameter int DVS_W = DIM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_dif;
  logic          ge;

  assign rem_sh  = {rem, quo[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_dif = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        // remainder stays below the divisor, so the low bits are enough
        rem <= ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/imt_seq.sv =====
// Transpose sequencer: walks permutation chains and swaps words through the RAM port.
`include "in_place_matrix_transpose_core_assert.svh"
module imt_seq
  import imt_pkg::*;
#(
  parameter int DEPTH      = IMT_DEPTH,
  parameter int WORD_WIDTH = IMT_WORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIM_W-1:0]         col_count,
  input  logic [DIM_W-1:0]         row_count,
  input  logic                     fin_ack,
  output seq_stat_t                stat,
  output ram_req_t                 ram,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [WORD_WIDTH-1:0]    wr_data,
  input  logic [WORD_WIDTH-1:0]    rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int TW = AW + 1;
  localparam int MW = 2 * DIM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHECK, S_TEST, S_DSTART, S_DWAIT, S_MAP, S_CMP,
    S_RD_P, S_RD_S, S_WR_S, S_WR_P, S_FIN
  } state_t;

  state_t              state;
  logic [MW-1:0]       total;
  logic [TW-1:0]       p;
  logic [AW-1:0]       s;
  logic                refused;
  logic [WORD_WIDTH-1:0] hold_p;
  logic [WORD_WIDTH-1:0] hold_s;

  logic                div_done;
  logic [AW-1:0]       div_quo;
  logic [DIM_W-1:0]    div_rem;
  logic [MW-1:0]       map_prod;
  logic [MW-1:0]       map_sum;

  imt_div #(
    .DVD_W(AW),
    .DVS_W(DIM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (s),
    .divisor  (col_count),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // next chain index: (s mod m) * n + s / m
  assign map_prod = MW'(div_rem) * MW'(row_count);
  assign map_sum  = map_prod + MW'(div_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_MUL;
        end
        S_MUL: begin
          total <= MW'(col_count) * MW'(row_count);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (total > MW'(DEPTH)) begin
            refused <= 1'b1;
            state   <= S_FIN;
          end else if (total < MW'(3)) begin
            // too small to need any move
            refused <= 1'b0;
            state   <= S_FIN;
          end else begin
            refused <= 1'b0;
            p       <= TW'(1);
            state   <= S_TEST;
          end
        end
        S_TEST: begin
          if (MW'(p) + MW'(2) < total) begin
            s     <= AW'(p);
            state <= S_DSTART;
          end else begin
            state <= S_FIN;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) state <= S_MAP;
        end
        S_MAP: begin
          s     <= AW'(map_sum);
          state <= S_CMP;
        end
        S_CMP: begin
          // keep following the chain until it lands at or above p
          if (TW'(s) < p) state <= S_DSTART;
          else state <= S_RD_P;
        end
        S_RD_P: state <= S_RD_S;
        S_RD_S: begin
          hold_p <= rd_data;
          state  <= S_WR_S;
        end
        S_WR_S: begin
          hold_s <= rd_data;
          state  <= S_WR_P;
        end
        S_WR_P: begin
          p     <= p + TW'(1);
          state <= S_TEST;
        end
        S_FIN: begin
          if (fin_ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy    = state != S_IDLE;
  assign stat.fin     = state == S_FIN;
  assign stat.refused = refused;

  assign ram.rd  = (state == S_RD_P) || (state == S_RD_S);
  assign ram.wr  = (state == S_WR_S) || (state == S_WR_P);
  assign rd_addr = (state == S_RD_P) ? AW'(p) : s;
  assign wr_addr = (state == S_WR_S) ? s : AW'(p);
  assign wr_data = (state == S_WR_S) ? hold_p : hold_s;

  `IMT_ASSERT_IMP(a_swap_range, state == S_RD_P, (MW'(p) < total) && (MW'(s) < total))
  `IMT_ASSERT_NEXT(a_swap_order, state == S_WR_S, state == S_WR_P)
  `IMT_ASSERT_IMP(a_div_wait, div_done, state == S_DWAIT)

endmodule

// ===== rtl/in_place_matrix_transpose_core.sv =====
// Top level of the in-place matrix transpose store.
//
// Input channel (in_valid / in_stall) carries one command per transaction:
// mode write stores data at index, mode read returns the word at index,
// mode transpose permutes the n x m column-major matrix (row_count x
// col_count) held at positions 0 .. m*n-1 into m x n in place.
// Output channel (out_valid / out_stall) carries one result per read or
// transpose: kind and read_data (zero unless kind is read data).
// Config channel (cfg_valid / cfg_ready, always ready) writes col_count or
// row_count by cfg_index; write it only while the block is idle.
// Writes and reads stream at one transaction per cycle while in_stall is low;
// a read result passes through the RAM output register, then the output register.
// A transpose holds in_stall for the whole walk: a setup step that multiplies
// and checks m*n, then per position one bit-serial division for each chain
// step plus a swap of two reads and two writes on the single RAM port.
// A refused transpose (m*n above DEPTH) skips the walk and reports kind refused.
// Reset sets both dimensions to 1 and empties the output; store contents
// are undefined until written. When the receiver stalls, the output
// register holds, one read may wait behind it, and then in_stall rises.
`include "in_place_matrix_transpose_core_assert.svh"
module in_place_matrix_transpose_core
  import imt_pkg::*;
#(
  parameter int DEPTH      = IMT_DEPTH,
  parameter int WORD_WIDTH = IMT_WORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    mode,
  input  logic [INDEX_W-1:0]   index,
  input  logic [DATA_W-1:0]    data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    kind,
  output logic [DATA_W-1:0]    read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic [DIM_W-1:0]      col_count;
  logic [DIM_W-1:0]      row_count;
  logic                  pend_valid;
  logic                  pend_hit;
  logic                  out_free;
  logic                  in_acc;
  logic                  in_range;
  logic                  fin_ack;

  seq_stat_t             seq_stat;
  ram_req_t              seq_ram;
  logic [AW-1:0]         seq_rd_addr;
  logic [AW-1:0]         seq_wr_addr;
  logic [WORD_WIDTH-1:0] seq_wr_data;

  logic                  ram_rd;
  logic                  ram_wr;
  logic [AW-1:0]         ram_rd_addr;
  logic [AW-1:0]         ram_wr_addr;
  logic [WORD_WIDTH-1:0] ram_wr_data;
  logic [WORD_WIDTH-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= DIM_W'(1);
      row_count <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COL_COUNT: col_count <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = seq_stat.busy || (pend_valid && !out_free);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = 32'(index) < 32'(DEPTH);
  assign fin_ack  = seq_stat.fin && !pend_valid && out_free;

  // sequencer owns the RAM port while a transpose runs
  assign ram_rd      = seq_stat.busy ? seq_ram.rd
                                     : (in_acc && mode == MODE_READ && in_range);
  assign ram_wr      = seq_stat.busy ? seq_ram.wr
                                     : (in_acc && mode == MODE_WRITE && in_range);
  assign ram_rd_addr = seq_stat.busy ? seq_rd_addr : AW'(index);
  assign ram_wr_addr = seq_stat.busy ? seq_wr_addr : AW'(index);
  assign ram_wr_data = seq_stat.busy ? seq_wr_data : WORD_WIDTH'(data);

  imt_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  imt_seq #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_acc && mode == MODE_TRANSPOSE),
    .col_count (col_count),
    .row_count (row_count),
    .fin_ack   (fin_ack),
    .stat      (seq_stat),
    .ram       (seq_ram),
    .rd_addr   (seq_rd_addr),
    .wr_addr   (seq_wr_addr),
    .wr_data   (seq_wr_data),
    .rd_data   (ram_rd_data)
  );

  // read data waits in the RAM output register while pend_valid holds
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc && mode == MODE_READ) begin
        pend_valid <= 1'b1;
        pend_hit   <= in_range;
      end else if (out_free) begin
        pend_valid <= 1'b0;
      end

      if (out_free) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          kind      <= KIND_READ;
          read_data <= pend_hit ? DATA_W'(ram_rd_data) : '0;
        end else if (seq_stat.fin) begin
          out_valid <= 1'b1;
          kind      <= seq_stat.refused ? KIND_REFUSED : KIND_DONE;
          read_data <= '0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  `IMT_ASSERT_NEXT(a_pend_hold, pend_valid && !out_free, pend_valid)
  `IMT_ASSERT_NEXT(a_fin_kind, fin_ack, out_valid && (kind != KIND_READ))
  `IMT_ASSERT_NEXT(a_read_pend, in_acc && (mode == MODE_READ), pend_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for in_place_matrix_transpose_core with an in-order transaction-level predictor.
module testbench;
  import imt_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
  localparam int                   SETTLE_CYCLES = 16;
  localparam int                   FULL_LOAD_MAX = 64;
  localparam int                   ITEM_TARGET   = 650;
  localparam logic [DATA_W-1:0]    ALL_ONES      = '1;
  localparam logic [DATA_W-1:0]    EDGE_WORD     = 64'h8000_0000_0000_0001;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] word;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   index;
    logic [DATA_W-1:0]    data;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [DIM_W-1:0]     reg_val;
    logic                 typed;
    outcome_t             want;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode      = MODE_WRITE;
  logic [INDEX_W-1:0]   index     = '0;
  logic [DATA_W-1:0]    data      = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [DATA_W-1:0]    read_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COL_COUNT;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // Shadow of the store, which entries hold written words, and the dimensions
  logic [DATA_W-1:0] store_copy  [IMT_DEPTH];
  bit                store_valid [IMT_DEPTH];
  logic [DIM_W-1:0]  cur_cols = 11'd1;
  logic [DIM_W-1:0]  cur_rows = 11'd1;

  outcome_t awaited [$];
  int       errors     = 0;
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       items_sent = 0;

  in_place_matrix_transpose_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .index     (index),
    .data      (data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAIL in_place_matrix_transpose_core");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    outcome_t head;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited.size() == 0) begin
        errors++;
        $error("unexpected result: kind %0d read_data %h", kind, read_data);
      end else begin
        head = awaited.pop_front();
        if (kind !== head.kind) begin
          errors++;
          $error("kind: expected %0d, got %0d", head.kind, kind);
        end
        if (read_data !== head.word) begin
          errors++;
          $error("read_data: expected %h, got %h", head.word, read_data);
        end
      end
    end
  end

  // Walk each chain from p until it lands at or above p, then swap.
  function automatic void permute_store();
    int unsigned       m, n, total, p, s;
    logic [DATA_W-1:0] w;
    bit                f;
    m = cur_cols;
    n = cur_rows;
    total = m * n;
    if (m == 0 || n == 0 || total < 3) return;
    for (p = 1; p < total - 2; p++) begin
      s = p;
      do s = (s % m) * n + s / m; while (s < p);
      w = store_copy[s];
      store_copy[s] = store_copy[p];
      store_copy[p] = w;
      f = store_valid[s];
      store_valid[s] = store_valid[p];
      store_valid[p] = f;
    end
  endfunction

  function automatic bit transpose_outcome(input logic [MODE_W-1:0] md,
                                           input logic [INDEX_W-1:0] ix,
                                           input logic [DATA_W-1:0] dt,
                                           output outcome_t res);
    bit has_res;
    has_res = 1'b0;
    res = '0;
    case (md)
      MODE_WRITE: begin
        store_copy[ix] = dt;
        store_valid[ix] = 1'b1;
      end
      MODE_READ: begin
        res.kind = KIND_READ;
        res.word = store_copy[ix];
        has_res = 1'b1;
      end
      MODE_TRANSPOSE: begin
        if (int'(cur_cols) * int'(cur_rows) > IMT_DEPTH) begin
          res.kind = KIND_REFUSED;
        end else begin
          permute_store();
          res.kind = KIND_DONE;
        end
        has_res = 1'b1;
      end
      default: has_res = 1'b0;
    endcase
    return has_res;
  endfunction

  function automatic plan_row_t item_row(input logic [MODE_W-1:0] md,
                                         input logic [INDEX_W-1:0] ix,
                                         input logic [DATA_W-1:0] dt,
                                         input logic typed = 1'b0,
                                         input logic [KIND_W-1:0] k = KIND_READ,
                                         input logic [DATA_W-1:0] w = '0);
    plan_row_t r;
    r = '0;
    r.op = ROW_ITEM;
    r.mode = md;
    r.index = ix;
    r.data = dt;
    r.typed = typed;
    r.want.kind = k;
    r.want.word = w;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                        input logic [DIM_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.op = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // Find a written entry, mostly inside the current matrix.
  function automatic logic [INDEX_W-1:0] pick_written(input int lim);
    int start;
    start = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                        : $urandom_range(0, IMT_DEPTH - 1);
    for (int k = 0; k < IMT_DEPTH; k++) begin
      if (store_valid[(start + k) % IMT_DEPTH]) return INDEX_W'((start + k) % IMT_DEPTH);
    end
    return '0;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] md, input logic [INDEX_W-1:0] ix,
                           input logic [DATA_W-1:0] dt, input logic typed = 1'b0,
                           input outcome_t want = '0);
    outcome_t res;
    in_valid <= 1'b1;
    mode <= md;
    index <= ix;
    data <= dt;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (transpose_outcome(md, ix, dt, res)) awaited.push_back(typed ? want : res);
    if (md != MODE_UNUSED) items_sent++;
  endtask

  task automatic pace();
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Hold off until every result is in and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (sel == REG_COL_COUNT) cur_cols = val;
    else if (sel == REG_ROW_COUNT) cur_rows = val;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n);
    settle();
    program_reg(REG_COL_COUNT, m);
    program_reg(REG_ROW_COUNT, n);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    plan_row_t plan [$];
    int        m, n, span, lim;

    plan.push_back(item_row(MODE_WRITE, 10'd0, ALL_ONES));
    plan.push_back(item_row(MODE_WRITE, 10'd1023, EDGE_WORD));
    plan.push_back(item_row(MODE_WRITE, 10'd1, '0));
    plan.push_back(item_row(MODE_READ, 10'd0, '0, 1'b1, KIND_READ, ALL_ONES));
    plan.push_back(item_row(MODE_READ, 10'd1023, '0, 1'b1, KIND_READ, EDGE_WORD));
    plan.push_back(item_row(MODE_READ, 10'd1, ALL_ONES, 1'b1, KIND_READ, '0));
    // unused mode must leave the store alone and stay silent
    plan.push_back(item_row(MODE_UNUSED, 10'd0, '0));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_DONE, '0));
    plan.push_back(item_row(MODE_READ, 10'd0, '0, 1'b1, KIND_READ, ALL_ONES));
    plan.push_back(reg_row(REG_UNUSED, 11'h7FF));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_DONE, '0));
    plan.push_back(reg_row(REG_COL_COUNT, 11'd0));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_DONE, '0));
    plan.push_back(reg_row(REG_COL_COUNT, 11'd2047));
    plan.push_back(reg_row(REG_ROW_COUNT, 11'd2047));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_REFUSED, '0));
    plan.push_back(reg_row(REG_COL_COUNT, 11'd1025));
    plan.push_back(reg_row(REG_ROW_COUNT, 11'd1));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_REFUSED, '0));
    // exactly the store depth, one row: every swap is a no-op
    plan.push_back(reg_row(REG_COL_COUNT, 11'd1024));
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0, 1'b1, KIND_DONE, '0));
    plan.push_back(item_row(MODE_READ, 10'd1023, '0, 1'b1, KIND_READ, EDGE_WORD));
    plan.push_back(reg_row(REG_COL_COUNT, 11'd2));
    plan.push_back(reg_row(REG_ROW_COUNT, 11'd2));
    for (int i = 0; i < 4; i++) begin
      plan.push_back(item_row(MODE_WRITE, INDEX_W'(i), 64'hA5A5_0000_0000_0000 | i));
    end
    plan.push_back(item_row(MODE_TRANSPOSE, 10'd0, '0));
    for (int i = 0; i < 4; i++) plan.push_back(item_row(MODE_READ, INDEX_W'(i), '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_REG) begin
        settle();
        program_reg(plan[i].reg_sel, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_item(plan[i].mode, plan[i].index, plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      case ($urandom_range(0, 19))
        0: begin
          m = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          n = (m == 0) ? $urandom_range(0, 8) : 0;
        end
        1, 2: begin
          m = $urandom_range(33, 2047);
          n = $urandom_range(32, 2047);
        end
        3, 4: begin
          case ($urandom_range(0, 4))
            0: begin m = 32; n = 32; end
            1: begin m = 16; n = 64; end
            2: begin m = 64; n = 16; end
            3: begin m = 1024; n = 1; end
            default: begin m = 1; n = 1024; end
          endcase
        end
        default: begin
          m = $urandom_range(1, 8);
          n = $urandom_range(1, 8);
        end
      endcase
      set_dims(DIM_W'(m), DIM_W'(n));

      case (ph % 5)
        1: begin idle_pct = 57; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 57; end
        3: begin idle_pct = 28; stall_pct = 28; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase

      span = m * n;
      lim = (span >= 1 && span <= IMT_DEPTH) ? span : IMT_DEPTH;

      // load the matrix, or a scattering of it when it is empty or large
      if (span >= 1 && span <= FULL_LOAD_MAX) begin
        for (int i = 0; i < span; i++) begin
          send_item(MODE_WRITE, INDEX_W'(i), rand_word());
          pace();
        end
      end else begin
        repeat (24) begin
          send_item(MODE_WRITE, INDEX_W'($urandom_range(0, lim - 1)), rand_word());
          pace();
        end
      end

      repeat ($urandom_range(4, 16)) begin
        case ($urandom_range(0, 9))
          0: send_item(MODE_UNUSED, INDEX_W'($urandom), rand_word());
          1, 2: send_item(MODE_WRITE, INDEX_W'($urandom), rand_word());
          3: send_item(MODE_TRANSPOSE, INDEX_W'($urandom), rand_word());
          default: send_item(MODE_READ, pick_written(lim), rand_word());
        endcase
        pace();
      end

      if (ph % 4 == 2) settle();
      send_item(MODE_TRANSPOSE, INDEX_W'($urandom), rand_word());
      pace();

      if (span >= 1 && span <= FULL_LOAD_MAX) begin
        for (int i = 0; i < span; i++) begin
          if (store_valid[i]) begin
            send_item(MODE_READ, INDEX_W'(i), rand_word());
            pace();
          end
        end
      end else begin
        repeat (24) begin
          send_item(MODE_READ, pick_written(lim), rand_word());
          pace();
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASS in_place_matrix_transpose_core");
    end else begin
      $display("FAIL in_place_matrix_transpose_core");
    end
    $finish;
  end

endmodule
